// ----- rtl/core/sdf_pkg.sv -----
// Shared constants, types and character codes for the signed decimal formatter.
// Depends on nothing; used by sdf_bin2bcd and signed_decimal_formatter_core.
package sdf_pkg;

    // input field width on the stream, and the part of it that is converted
    localparam int IN_W        = 64;
    localparam int VALUE_WIDTH = 64;   // 8 .. 64

    // decimal digits for a VALUE_WIDTH-bit unsigned magnitude: floor(W*log10(2)) + 1
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int DIG_IW     = $clog2(NUM_DIGITS);       // digit index
    localparam int DIG_CW     = $clog2(NUM_DIGITS + 1);   // digit count
    localparam int BIT_CW     = $clog2(VALUE_WIDTH + 1);  // bit counter

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // converter status toward the formatter control
    typedef struct packed {
        logic              busy;
        logic              done;     // one cycle, conversion finished
        logic [DIG_CW-1:0] ndig;     // significant digits, at least 1
        logic [1:0]        lead_m3;  // (ndig - 1) mod 3
    } conv_stat_t;

endpackage

// ----- rtl/core/signed_decimal_formatter_core.sv -----
// Signed decimal formatter: one signed value in, its ASCII text out a character a transfer.
// Depends on sdf_pkg and sdf_bin2bcd.
//
// Usage:
//   s_ channel: one transfer carries the value to print (s_tdata, two's complement,
//   low VALUE_WIDTH bits used). s_tready is high only while the block is idle.
//   m_ channel: one transfer per character, most significant first: an optional
//   '-', the digits, and ',' between groups of three when group_thousands is 1.
//   m_tlast marks the final character. 1 to 26 transfers per value.
//   cfg channel: cfg_data[0] sets group_thousands; write only while idle.
// Timing:
//   After the input transfer the converter shifts in one magnitude bit per cycle
//   through the shift-and-add-3 register; once it is done, the sequencer leaves
//   its conversion state and the first character is registered. Characters then
//   leave one per cycle while m_tready is high. The next value is accepted once the
//   last character sits in the output register.
// Reset: aresetn clears the control, the output valid and group_thousands.
// Stall: a low m_tready holds the current character; the sequencer waits.
module signed_decimal_formatter_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sdf_pkg::IN_W-1:0]   s_tdata,   // [63:0] number
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] character
    output logic                       m_tlast,   // last_char
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data   // group_thousands
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SIGN  = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_COMMA = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic                             group_reg;
    logic                             neg_reg,   neg_next;
    logic [sdf_pkg::DIG_IW-1:0]       pos_reg,   pos_next;
    logic [1:0]                       m3_reg,    m3_next;
    logic                             tvalid_reg, tvalid_next;
    logic [7:0]                       char_reg,  char_next;
    logic                             last_reg,  last_next;

    logic                             in_xfer;
    logic                             out_ok;
    logic [sdf_pkg::VALUE_WIDTH-1:0]  raw;
    logic [sdf_pkg::VALUE_WIDTH-1:0]  magnitude;
    logic [sdf_pkg::BCD_W-1:0]        bcd;
    sdf_pkg::conv_stat_t              conv_stat;
    logic [sdf_pkg::DIG_CW-1:0]       lead_pos;
    logic [3:0]                       cur_dig;
    logic                             comma_here;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // two's complement magnitude; the most negative value comes out right as unsigned
    assign raw       = s_tdata[sdf_pkg::VALUE_WIDTH-1:0];
    assign magnitude = raw[sdf_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    sdf_bin2bcd u_bin2bcd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_xfer),
        .magnitude (magnitude),
        .bcd       (bcd),
        .stat      (conv_stat)
    );

    assign lead_pos   = conv_stat.ndig - 1'b1;
    assign cur_dig    = bcd[pos_reg*4 +: 4];
    assign comma_here = group_reg && (pos_reg != '0) && (m3_reg == 2'd0);
    assign out_ok     = !tvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        pos_next    = pos_reg;
        m3_next     = m3_reg;
        tvalid_next = tvalid_reg && !m_tready;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    neg_next   = raw[sdf_pkg::VALUE_WIDTH-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_stat.done) begin
                    pos_next   = lead_pos[sdf_pkg::DIG_IW-1:0];
                    m3_next    = conv_stat.lead_m3;
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_ok) begin
                    tvalid_next = 1'b1;
                    char_next   = sdf_pkg::CH_MINUS;
                    last_next   = 1'b0;
                    state_next  = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_ok) begin
                    tvalid_next = 1'b1;
                    char_next   = sdf_pkg::CH_ZERO + {4'd0, cur_dig};
                    last_next   = (pos_reg == '0);
                    if (comma_here) begin
                        state_next = ST_COMMA;
                    end else if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                        m3_next  = (m3_reg == 2'd0) ? 2'd2 : m3_reg - 2'd1;
                    end
                end
            end
            ST_COMMA: begin
                if (out_ok) begin
                    tvalid_next = 1'b1;
                    char_next   = sdf_pkg::CH_COMMA;
                    last_next   = 1'b0;
                    pos_next    = pos_reg - 1'b1;
                    m3_next     = 2'd2;
                    state_next  = ST_DIGIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tvalid_reg <= 1'b0;
            group_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
            if (cfg_valid && cfg_ready) begin
                group_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        pos_reg  <= pos_next;
        m3_reg   <= m3_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    // an accepted value starts the converter at the next edge
    a_conv_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> conv_stat.busy)
        else $error("converter not started after input transfer");

    // the converter only finishes while the sequencer waits for it
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_stat.done |-> (state_reg == ST_CONV))
        else $error("conversion finished outside of conversion state");

    // only minus, comma or a digit ever leaves
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == sdf_pkg::CH_MINUS || m_tdata == sdf_pkg::CH_COMMA ||
                      (m_tdata >= sdf_pkg::CH_ZERO && m_tdata <= sdf_pkg::CH_NINE)))
        else $error("unexpected output character");

    // a held character does not change under stall
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

// ----- rtl/core/sdf_bin2bcd.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit a cycle.
// Depends on sdf_pkg; also tracks the count of significant decimal digits.
module sdf_bin2bcd (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [sdf_pkg::VALUE_WIDTH-1:0]   magnitude,
    output logic [sdf_pkg::BCD_W-1:0]         bcd,
    output sdf_pkg::conv_stat_t               stat
);

    logic [sdf_pkg::VALUE_WIDTH-1:0] mag_reg,  mag_next;
    logic [sdf_pkg::BCD_W-1:0]       bcd_reg,  bcd_next;
    logic [sdf_pkg::BIT_CW-1:0]      cnt_reg,  cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [sdf_pkg::DIG_CW-1:0]      ndig_reg, ndig_next;
    logic [1:0]                      m3_reg,   m3_next;
    logic [sdf_pkg::BCD_W-1:0]       adj;
    logic [sdf_pkg::BCD_W-1:0]       shifted;
    logic [3:0]                      next_dig;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < sdf_pkg::NUM_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    assign shifted = {adj[sdf_pkg::BCD_W-2:0], mag_reg[sdf_pkg::VALUE_WIDTH-1]};

    // digit just above the current top one; count grows by at most one per shift
    always_comb begin
        if (ndig_reg < sdf_pkg::DIG_CW'(sdf_pkg::NUM_DIGITS)) begin
            next_dig = shifted[ndig_reg[sdf_pkg::DIG_IW-1:0]*4 +: 4];
        end else begin
            next_dig = 4'd0;
        end
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ndig_next = ndig_reg;
        m3_next   = m3_reg;
        if (start) begin
            mag_next  = magnitude;
            bcd_next  = '0;
            cnt_next  = sdf_pkg::BIT_CW'(sdf_pkg::VALUE_WIDTH);
            busy_next = 1'b1;
            ndig_next = sdf_pkg::DIG_CW'(1);
            m3_next   = 2'd0;
        end else if (busy_reg) begin
            mag_next = {mag_reg[sdf_pkg::VALUE_WIDTH-2:0], 1'b0};
            bcd_next = shifted;
            cnt_next = cnt_reg - 1'b1;
            if (next_dig != 4'd0) begin
                ndig_next = ndig_reg + 1'b1;
                m3_next   = (m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
            end
            if (cnt_reg == sdf_pkg::BIT_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            ndig_reg <= sdf_pkg::DIG_CW'(1);
            m3_reg   <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            ndig_reg <= ndig_next;
            m3_reg   <= m3_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign bcd          = bcd_reg;
    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.ndig    = ndig_reg;
    assign stat.lead_m3 = m3_reg;

endmodule
